/* rtl/oic_pkg.sv */
// ----------------------------------------------------------------------------
// oic_pkg
// Shared constants, state codes and the square-root table of the obstacle
// inflation cost map.
// ----------------------------------------------------------------------------
package oic_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_RADIUS = 15;

  localparam int CELLS   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int PEN_W   = 16;
  localparam int DIM_W   = 9;
  localparam int SQ_W    = 20;
  localparam int NUM_W   = 30;
  localparam int QUO_W   = 10;

  localparam logic [PEN_W-1:0] OBSTACLE = 16'hFFFF;
  localparam logic [PEN_W-1:0] GOAL     = 16'hFFFE;
  localparam logic [QUO_W-1:0] PEN_SCALE = 10'd1000;

  localparam logic [7:0] THRESH_RST = 8'd205;

  typedef enum logic [2:0] {
    REG_THRESH = 3'd0,
    REG_RADIUS = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_GOALC  = 3'd4,
    REG_GOALR  = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_DATA,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_NB_SETUP,
    ST_DIV,
    ST_NB_RD,
    ST_NB_CHK,
    ST_GOAL
  } state_t;

  typedef logic [SQ_W-1:0] sqrt_lut_t [256];

  // floor(sqrt(v)), bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = v;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // sqrt(d2) with 16 fraction bits, truncated
  function automatic sqrt_lut_t build_sqrt_lut();
    sqrt_lut_t t;
    logic [63:0] s;
    for (int d = 0; d < 256; d++) begin
      s = isqrt64(64'(d) << 32);
      t[d] = s[SQ_W-1:0];
    end
    return t;
  endfunction

  localparam sqrt_lut_t SQRT_LUT = build_sqrt_lut();

endpackage

/* rtl/oic_ram.sv */
// ----------------------------------------------------------------------------
// oic_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oic_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/obstacle_inflation_costmap_top.sv */
// ----------------------------------------------------------------------------
// obstacle_inflation_costmap_top
// Loads an occupancy grid pixel by pixel, inflates obstacles with a linear
// penalty once the grid is full, marks the goal and serves cell reads.
// ----------------------------------------------------------------------------
// load beat: the last pixel starts the finish pass (ready low)
// read beat: an off-grid result is registered on accept; an in-grid read goes
//   through ST_RD_DATA (ram read); finish pass: each cell is scanned, each
//   obstacle steps its (2r+1)^2 offsets, and each offset inside the radius and
//   the grid runs the 10-step divider and a ram read-modify-write; then the
//   goal mark. Synchronous active-low reset clears control and registers; the
//   map ram is not cleared
module obstacle_inflation_costmap_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_pixel_value,
  input  logic [7:0]  in_read_col,
  input  logic [7:0]  in_read_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_cell_penalty,
  output logic        out_out_of_grid,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import oic_pkg::*;

  state_t state_r, state_nxt;

  logic [7:0]       thresh_r;
  logic [3:0]       radius_r;
  logic [DIM_W-1:0] gw_r, gh_r, goalc_r, goalr_r;

  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic              done_r, done_nxt;
  logic [7:0]        x_r, x_nxt, y_r, y_nxt;
  logic signed [4:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [ADDR_W-1:0] nb_addr_r, nb_addr_nxt;
  logic [NUM_W-1:0]  rem_r, rem_nxt;
  logic [SQ_W-1:0]   den_r, den_nxt;
  logic [QUO_W-1:0]  q_r, q_nxt;
  logic [3:0]        step_r, step_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_pen_r, out_pen_nxt;
  logic        out_oog_r, out_oog_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [PEN_W-1:0]  ram_wdata, ram_rdata;

  // effective geometry
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [3:0]       r_eff;
  logic [16:0]      total;
  always_comb begin
    w_eff = (gw_r == '0) ? DIM_W'(1) : ((gw_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : gw_r);
    h_eff = (gh_r == '0) ? DIM_W'(1) : ((gh_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : gh_r);
    r_eff = (radius_r > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : radius_r;
    total = 17'(w_eff) * 17'(h_eff);
  end

  logic accept, cfg_we;
  assign accept = in_valid && in_ready;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
      radius_r <= '0;
      gw_r     <= DIM_W'(MAX_WIDTH);
      gh_r     <= DIM_W'(MAX_HEIGHT);
      goalc_r  <= '1;
      goalr_r  <= '1;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_THRESH: thresh_r <= pwdata[7:0];
        REG_RADIUS: radius_r <= pwdata[3:0];
        REG_WIDTH:  gw_r     <= pwdata[DIM_W-1:0];
        REG_HEIGHT: gh_r     <= pwdata[DIM_W-1:0];
        REG_GOALC:  goalc_r  <= pwdata[DIM_W-1:0];
        REG_GOALR:  goalr_r  <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_THRESH: prdata = 32'(thresh_r);
      REG_RADIUS: prdata = 32'(radius_r);
      REG_WIDTH:  prdata = 32'(gw_r);
      REG_HEIGHT: prdata = 32'(gh_r);
      REG_GOALC:  prdata = 32'(goalc_r);
      REG_GOALR:  prdata = 32'(goalr_r);
      default:    prdata = '0;
    endcase
  end

  // neighbor geometry for the current offset
  logic signed [9:0] nx, ny;
  logic [8:0]        d2;
  logic [7:0]        rr;
  logic              nb_ok;
  logic [16:0]       nb_addr_full;
  logic [SQ_W-1:0]   r_fix, s_fix;
  logic [NUM_W-1:0]  numer;
  always_comb begin
    nx = $signed({2'b00, x_r}) + 10'(dx_r);
    ny = $signed({2'b00, y_r}) + 10'(dy_r);
    d2 = 9'(dx_r * dx_r) + 9'(dy_r * dy_r);
    rr = 8'(r_eff) * 8'(r_eff);
    nb_ok = !nx[9] && !ny[9] && (nx < $signed({1'b0, w_eff})) &&
            (ny < $signed({1'b0, h_eff})) && (d2 <= 9'(rr));
    nb_addr_full = 17'(ny[7:0]) * 17'(w_eff) + 17'(nx[7:0]);
    r_fix = {r_eff, 16'h0000};
    s_fix = SQRT_LUT[d2[7:0]];
    numer = NUM_W'(r_fix - s_fix) * NUM_W'(PEN_SCALE);
  end

  // divider step
  logic [NUM_W-1:0] trial;
  assign trial = NUM_W'(den_r) << step_r;

  // other addresses
  logic              rd_oog;
  logic [16:0]       rd_addr_full, scan_addr_full, goal_addr_full;
  logic              goal_in;
  logic [ADDR_W-1:0] ld_pos;
  logic              last_off, last_cell;
  always_comb begin
    rd_oog = (DIM_W'(in_read_col) >= w_eff) || (DIM_W'(in_read_row) >= h_eff);
    rd_addr_full   = 17'(in_read_row) * 17'(w_eff) + 17'(in_read_col);
    scan_addr_full = 17'(y_r) * 17'(w_eff) + 17'(x_r);
    goal_in = !goalc_r[8] && !goalr_r[8] && (goalc_r < w_eff) && (goalr_r < h_eff);
    goal_addr_full = 17'(goalr_r[7:0]) * 17'(w_eff) + 17'(goalc_r[7:0]);
    ld_pos = done_r ? '0 : pos_r;
    last_off  = (dx_r == $signed({1'b0, r_eff})) && (dy_r == $signed({1'b0, r_eff}));
    last_cell = (DIM_W'(x_r) == w_eff - 1'b1) && (DIM_W'(y_r) == h_eff - 1'b1);
  end

  // ram ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ld_pos;
    ram_wdata = (in_pixel_value >= thresh_r) ? OBSTACLE : '0;
    ram_raddr = rd_addr_full[ADDR_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        ram_we = accept && !in_op && (17'(ld_pos) < total);
      end
      ST_SCAN_RD: begin
        ram_raddr = scan_addr_full[ADDR_W-1:0];
      end
      ST_NB_RD: begin
        ram_raddr = nb_addr_r;
      end
      ST_NB_CHK: begin
        ram_we    = (ram_rdata != OBSTACLE) && (PEN_W'(q_r) > ram_rdata);
        ram_waddr = nb_addr_r;
        ram_wdata = PEN_W'(q_r);
      end
      ST_GOAL: begin
        ram_we    = goal_in;
        ram_waddr = goal_addr_full[ADDR_W-1:0];
        ram_wdata = GOAL;
      end
      default: ;
    endcase
  end

  oic_ram #(.WIDTH(PEN_W), .DEPTH(CELLS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op) begin
            state_nxt = rd_oog ? ST_IDLE : ST_RD_DATA;
          end else if (17'(ld_pos) + 17'd1 >= total) begin
            state_nxt = (r_eff != '0) ? ST_SCAN_RD : ST_GOAL;
          end
        end
      end
      ST_RD_DATA:  state_nxt = ST_IDLE;
      ST_SCAN_RD:  state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (ram_rdata == OBSTACLE) begin
          state_nxt = ST_NB_SETUP;
        end else begin
          state_nxt = last_cell ? ST_GOAL : ST_SCAN_RD;
        end
      end
      ST_NB_SETUP: begin
        if (nb_ok) begin
          state_nxt = ST_DIV;
        end else if (last_off) begin
          state_nxt = last_cell ? ST_GOAL : ST_SCAN_RD;
        end
      end
      ST_DIV:   state_nxt = (step_r == '0) ? ST_NB_RD : ST_DIV;
      ST_NB_RD: state_nxt = ST_NB_CHK;
      ST_NB_CHK: begin
        if (last_off) begin
          state_nxt = last_cell ? ST_GOAL : ST_SCAN_RD;
        end else begin
          state_nxt = ST_NB_SETUP;
        end
      end
      ST_GOAL: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and output updates
  always_comb begin
    pos_nxt       = pos_r;
    done_nxt      = done_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    nb_addr_nxt   = nb_addr_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_pen_nxt   = out_pen_r;
    out_oog_nxt   = out_oog_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op) begin
            if (rd_oog) begin
              out_valid_nxt = 1'b1;
              out_pen_nxt   = '0;
              out_oog_nxt   = 1'b1;
            end
          end else begin
            done_nxt = 1'b0;
            pos_nxt  = ld_pos + 1'b1;
            x_nxt    = '0;
            y_nxt    = '0;
          end
        end
      end
      ST_RD_DATA: begin
        out_valid_nxt = 1'b1;
        out_pen_nxt   = ram_rdata;
        out_oog_nxt   = 1'b0;
      end
      ST_SCAN_CHK: begin
        dx_nxt = -$signed({1'b0, r_eff});
        dy_nxt = -$signed({1'b0, r_eff});
      end
      ST_NB_SETUP: begin
        nb_addr_nxt = nb_addr_full[ADDR_W-1:0];
        rem_nxt     = numer;
        den_nxt     = r_fix;
        q_nxt       = '0;
        step_nxt    = 4'(QUO_W - 1);
      end
      ST_DIV: begin
        if (rem_r >= trial) begin
          rem_nxt = rem_r - trial;
          q_nxt   = q_r | (QUO_W'(1) << step_r);
        end
        step_nxt = step_r - 1'b1;
      end
      ST_GOAL: begin
        done_nxt = 1'b1;
        pos_nxt  = '0;
      end
      default: ;
    endcase

    // offset and cell stepping
    if ((state_r == ST_NB_SETUP && !nb_ok) || state_r == ST_NB_CHK) begin
      if (dx_r == $signed({1'b0, r_eff})) begin
        dx_nxt = -$signed({1'b0, r_eff});
        dy_nxt = dy_r + 1'b1;
      end else begin
        dx_nxt = dx_r + 1'b1;
      end
    end
    if ((state_r == ST_SCAN_CHK && ram_rdata != OBSTACLE) ||
        (((state_r == ST_NB_SETUP && !nb_ok) || state_r == ST_NB_CHK) && last_off)) begin
      if (DIM_W'(x_r) == w_eff - 1'b1) begin
        x_nxt = '0;
        y_nxt = y_r + 1'b1;
      end else begin
        x_nxt = x_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    nb_addr_r <= nb_addr_nxt;
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    q_r       <= q_nxt;
    step_r    <= step_nxt;
    out_pen_r <= out_pen_nxt;
    out_oog_r <= out_oog_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_cell_penalty = out_pen_r;
  assign out_out_of_grid  = out_oog_r;

  // map writes only from load, inflation update or goal mark
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE || state_r == ST_NB_CHK || state_r == ST_GOAL))
    else $error("map write outside a writing state");

  // inflation penalty never exceeds the scale
  a_pen_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NB_CHK) |-> (q_r <= PEN_SCALE))
    else $error("inflation penalty above scale");

  // an out-of-grid read shows its beat on the next cycle
  a_oog_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op && rd_oog) |=> (out_valid_r && out_oog_r && out_pen_r == '0))
    else $error("out-of-grid read response missing");

  // a read inside the grid always returns through the data state
  a_rd_path: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op && !rd_oog) |=> (state_r == ST_RD_DATA))
    else $error("read did not enter data state");

  // divider stays in its state until its last step
  a_div_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && step_r != '0) |=> (state_r == ST_DIV))
    else $error("divider left early");

endmodule

/* tb/sv/tb_obstacle_inflation_costmap_top.sv */
// ----------------------------------------------------------------------------
// tb_obstacle_inflation_costmap_top
// Self-checking bench for the obstacle inflation cost map: loads grids,
// reconfigures between maps and checks every cell read against a cost map
// predictor that inflates obstacles and marks the goal.
// ----------------------------------------------------------------------------
module tb_obstacle_inflation_costmap_top;
  import oic_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam int   CYCLE_LIMIT = 40000000;

  typedef struct packed {
    logic [15:0] penalty;
    logic        off_grid;
  } cell_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = 1'b0;
  logic [7:0]  in_pixel_value = '0;
  logic [7:0]  in_read_col = '0;
  logic [7:0]  in_read_row = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_cell_penalty;
  logic        out_out_of_grid;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  obstacle_inflation_costmap_top uut (.*);

  always #5 clk = ~clk;

  // cost map predictor state
  logic [7:0]  thresh_q;
  logic [3:0]  radius_q;
  logic [8:0]  width_q, height_q, goal_col_q, goal_row_q;
  logic [15:0] cost_map [CELLS];
  bit          cell_written [CELLS];
  int          load_pos;
  bit          map_done;

  cell_beat_t  expected_cells[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          calm = 1'b0;

  function automatic int grid_w();
    if (width_q == 0) return 1;
    return (width_q > MAX_WIDTH) ? MAX_WIDTH : int'(width_q);
  endfunction

  function automatic int grid_h();
    if (height_q == 0) return 1;
    return (height_q > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_q);
  endfunction

  // largest s with s*s <= d2 * 2^32
  function automatic longint unsigned dist_q16(int d2);
    longint unsigned s, t, target;
    target = longint'(d2) << 32;
    s = 0;
    for (int b = 22; b >= 0; b--) begin
      t = s | (64'd1 << b);
      if (t * t <= target) s = t;
    end
    return s;
  endfunction

  function automatic void inflate_and_mark();
    int w, h, r, gx, gy, ny, nx;
    longint unsigned big_r, s;
    logic [15:0] ramp [-MAX_RADIUS:MAX_RADIUS][-MAX_RADIUS:MAX_RADIUS];
    w = grid_w();
    h = grid_h();
    r = int'(radius_q);
    gx = int'($signed(goal_col_q));
    gy = int'($signed(goal_row_q));
    if (r > 0) begin
      big_r = longint'(r) << 16;
      for (int dy = -r; dy <= r; dy++)
        for (int dx = -r; dx <= r; dx++) begin
          ramp[dy][dx] = 16'd0;
          if (dx * dx + dy * dy <= r * r) begin
            s = dist_q16(dx * dx + dy * dy);
            ramp[dy][dx] = 16'((64'd1000 * (big_r - s)) / big_r);
          end
        end
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          if (cost_map[y * w + x] != OBSTACLE) continue;
          for (int dy = -r; dy <= r; dy++) begin
            ny = y + dy;
            if (ny < 0 || ny >= h) continue;
            for (int dx = -r; dx <= r; dx++) begin
              nx = x + dx;
              if (nx < 0 || nx >= w) continue;
              if (dx * dx + dy * dy > r * r) continue;
              if (cost_map[ny * w + nx] == OBSTACLE) continue;
              if (ramp[dy][dx] > cost_map[ny * w + nx])
                cost_map[ny * w + nx] = ramp[dy][dx];
            end
          end
        end
    end
    if (gx >= 0 && gx < w && gy >= 0 && gy < h) begin
      cost_map[gy * w + gx] = GOAL;
      cell_written[gy * w + gx] = 1'b1;
    end
    load_pos = 0;
    map_done = 1'b1;
  endfunction

  function automatic void predict_beat(logic op, logic [7:0] pix, logic [7:0] col,
                                       logic [7:0] row);
    int w, h, total;
    cell_beat_t e;
    w = grid_w();
    h = grid_h();
    total = w * h;
    if (op == OP_LOAD) begin
      if (map_done) begin
        map_done = 1'b0;
        load_pos = 0;
      end
      if (load_pos < total) begin
        cost_map[load_pos] = (pix >= thresh_q) ? OBSTACLE : 16'd0;
        cell_written[load_pos] = 1'b1;
      end
      load_pos++;
      if (load_pos >= total) inflate_and_mark();
    end else begin
      if (col >= w || row >= h) begin
        e.penalty = '0;
        e.off_grid = 1'b1;
      end else begin
        e.penalty = cost_map[row * w + col];
        e.off_grid = 1'b0;
      end
      expected_cells.push_back(e);
    end
  endfunction

  // result side: random stall, none while calm
  always @(negedge clk) out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_cells.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected beat: penalty=%0d off_grid=%0b", out_cell_penalty,
                   out_out_of_grid);
      end else begin
        cell_beat_t e;
        e = expected_cells.pop_front();
        if (out_cell_penalty !== e.penalty || out_out_of_grid !== e.off_grid) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("cell mismatch: exp penalty=%0d off_grid=%0b got penalty=%0d off_grid=%0b",
                     e.penalty, e.off_grid, out_cell_penalty, out_out_of_grid);
        end
      end
    end
  end

  task automatic send_beat(logic op, logic [7:0] pix, logic [7:0] col, logic [7:0] row);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_pixel_value <= pix;
    in_read_col <= col;
    in_read_row <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_beat(op, pix, col, row);
  endtask

  task automatic load_pixel(logic [7:0] pix);
    send_beat(OP_LOAD, pix, 8'($urandom), 8'($urandom));
  endtask

  // reads a cell, steering away from cells never written since reset
  task automatic read_cell(logic [7:0] col, logic [7:0] row);
    if (col < grid_w() && row < grid_h() && !cell_written[row * grid_w() + col]) begin
      col = 8'hFF;
      row = 8'hFF;
    end
    send_beat(OP_READ, 8'($urandom), col, row);
  endtask

  // an off-grid read waits out any finish pass, then all beats drain
  task automatic settle();
    read_cell(8'hFF, 8'hFF);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [8:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 5'(idx) << 2;
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_THRESH: thresh_q = value[7:0];
      REG_RADIUS: radius_q = value[3:0];
      REG_WIDTH:  width_q = value;
      REG_HEIGHT: height_q = value;
      REG_GOALC:  goal_col_q = value;
      default:    goal_row_q = value;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_small_grid();
    cfg_write(REG_WIDTH, 9'd4);
    cfg_write(REG_HEIGHT, 9'd3);
    load_pixel(8'd0);
    load_pixel(8'd204);
    read_cell(8'd1, 8'd0);
    load_pixel(8'd205);
    load_pixel(8'd255);
    repeat (8) load_pixel(8'd10);
    read_cell(8'd2, 8'd0);
    read_cell(8'd3, 8'd2);
    read_cell(8'd4, 8'd0);
    read_cell(8'd0, 8'd3);
    read_cell(8'd255, 8'd255);
    settle();
  endtask

  task automatic test_goal_on_obstacle();
    cfg_write(REG_THRESH, 9'd0);
    cfg_write(REG_RADIUS, 9'd1);
    cfg_write(REG_WIDTH, 9'd3);
    cfg_write(REG_HEIGHT, 9'd3);
    cfg_write(REG_GOALC, 9'd1);
    cfg_write(REG_GOALR, 9'd1);
    repeat (9) load_pixel(8'd0);
    for (int i = 0; i < 3; i++) read_cell(8'(i), 8'(i));
    settle();
    cfg_write(REG_GOALC, 9'h1FF);
    cfg_write(REG_THRESH, 9'd255);
    for (int i = 0; i < 9; i++) load_pixel((i == 4) ? 8'd255 : 8'd254);
    read_cell(8'd1, 8'd1);
    read_cell(8'd0, 8'd0);
    settle();
  endtask

  // width saturates, zero height counts as one row, widest radius
  task automatic test_wide_row();
    cfg_write(REG_WIDTH, 9'h1FF);
    cfg_write(REG_HEIGHT, 9'd0);
    cfg_write(REG_RADIUS, 9'd15);
    cfg_write(REG_GOALC, 9'd255);
    cfg_write(REG_GOALR, 9'd0);
    for (int i = 0; i < 256; i++)
      load_pixel((i == 0 || i == 100 || i == 120 || i == 250) ? 8'd255 : 8'($urandom_range(254)));
    read_cell(8'd0, 8'd0);
    for (int c = 100; c <= 116; c++) read_cell(8'(c), 8'd0);
    read_cell(8'd255, 8'd0);
    read_cell(8'd5, 8'd1);
    settle();
  endtask

  task automatic test_shrink_mid_load();
    cfg_write(REG_RADIUS, 9'd2);
    cfg_write(REG_WIDTH, 9'd8);
    cfg_write(REG_HEIGHT, 9'd8);
    cfg_write(REG_GOALC, 9'd0);
    cfg_write(REG_GOALR, 9'h100);
    repeat (10) load_pixel(8'($urandom));
    settle();
    cfg_write(REG_WIDTH, 9'd2);
    cfg_write(REG_HEIGHT, 9'd2);
    load_pixel(8'd255);
    for (int i = 0; i < 3; i++) read_cell(8'(i), 8'(i & 1));
    settle();
  endtask

  task automatic test_random_maps();
    int sent, w, h, phase;
    sent = 0;
    phase = 0;
    while (sent < 250) begin
      calm = (phase == 1 || phase == 2);
      w = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      h = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(12, 1);
      cfg_write(REG_THRESH, 9'($urandom_range(255, 128)));
      cfg_write(REG_RADIUS, 9'($urandom_range(15)));
      cfg_write(REG_WIDTH, 9'(w));
      cfg_write(REG_HEIGHT, 9'(h));
      cfg_write(REG_GOALC, ($urandom_range(4) == 0) ? 9'($urandom) : 9'($urandom_range(w)));
      cfg_write(REG_GOALR, ($urandom_range(4) == 0) ? 9'($urandom) : 9'($urandom_range(h)));
      for (int i = 0; i < w * h; i++) begin
        load_pixel(8'($urandom));
        sent++;
        if ($urandom_range(99) < 20) begin
          read_cell(8'($urandom_range(w)), 8'($urandom_range(h)));
          sent++;
        end
      end
      repeat ($urandom_range(12, 4)) begin
        if ($urandom_range(9) == 0) read_cell(8'($urandom), 8'($urandom));
        else read_cell(8'($urandom_range(w - 1)), 8'($urandom_range(h - 1)));
        sent++;
      end
      settle();
      phase++;
    end
    calm = 1'b0;
  endtask

  initial begin
    thresh_q = THRESH_RST;
    radius_q = '0;
    width_q = 9'd256;
    height_q = 9'd256;
    goal_col_q = 9'h1FF;
    goal_row_q = 9'h1FF;
    load_pos = 0;
    map_done = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_small_grid();
    test_goal_on_obstacle();
    test_wide_row();
    test_shrink_mid_load();
    test_random_maps();
    while (expected_cells.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
